// File: rtl/sba_pkg.sv
`timescale 1ns / 1ps

package sba_pkg;

    // fixed field widths
    localparam int REQ_W    = 16;
    localparam int SIZE_W   = 17;
    localparam int HANDLE_W = 7;

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED     = 2'd0,
        ST_FREED         = 2'd1,
        ST_NO_SPACE      = 2'd2,
        ST_NOT_ALLOCATED = 2'd3
    } t_status;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FREE_CHK,
        BK_DONE
    } t_back_state;

endpackage

// File: rtl/sba_ram.sv
`timescale 1ns / 1ps

module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/sba_front.sv
`timescale 1ns / 1ps

module sba_front #(
    parameter int PAGES_PER_BIN = 8,
    parameter int ALIGN_BYTES   = 32,
    parameter int SW            = 3,
    parameter int ITEM_W        = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [sba_pkg::REQ_W-1:0]    i_request_size,
    input  logic [sba_pkg::HANDLE_W-1:0] i_slot_handle,
    output logic                         o_push,
    output logic [ITEM_W-1:0]            o_item,
    input  logic                         i_full
);

    // exact reciprocals for division by the alignment and by the bin size
    localparam int          S1  = sba_pkg::SIZE_W + $clog2(ALIGN_BYTES);
    localparam logic [18:0] R1  = 19'(((longint'(1) << S1) + ALIGN_BYTES - 1) / ALIGN_BYTES);
    localparam int          S2  = sba_pkg::HANDLE_W + $clog2(PAGES_PER_BIN);
    localparam logic [8:0]  R2  = 9'(((longint'(1) << S2) + PAGES_PER_BIN - 1) / PAGES_PER_BIN);
    localparam int          P1W = sba_pkg::SIZE_W + 19;
    localparam int          P2W = sba_pkg::HANDLE_W + 9;
    localparam int          NPW = sba_pkg::SIZE_W + 13;
    localparam int          BPW = 2 * sba_pkg::HANDLE_W;

    logic                              r1_vld, r1_op;
    logic [sba_pkg::SIZE_W-1:0]        r1_x;
    logic [sba_pkg::HANDLE_W-1:0]      r1_handle;
    logic                              r2_vld, r2_op;
    logic [sba_pkg::SIZE_W-1:0]        r2_q;
    logic [sba_pkg::HANDLE_W-1:0]      r2_bin, r2_handle;

    logic                              load1, load2, adv2;
    logic [P1W-1:0]                    prod1, shr1;
    logic [P2W-1:0]                    prod2, shr2;
    logic [NPW-1:0]                    need_full;
    logic [BPW-1:0]                    slot_full;

    // stage handshakes
    assign adv2    = r2_vld && !i_full;
    assign load2   = r1_vld && (!r2_vld || adv2);
    assign o_stall = r1_vld && !load2;
    assign load1   = i_valid && !o_stall;
    assign o_push  = adv2;

    // quotients by reciprocal multiply
    assign prod1 = P1W'(r1_x) * P1W'(R1);
    assign shr1  = prod1 >> S1;
    assign prod2 = P2W'(r1_handle) * P2W'(R2);
    assign shr2  = prod2 >> S2;

    // rounded size and slot index
    assign need_full = NPW'(r2_q) * NPW'(ALIGN_BYTES);
    assign slot_full = BPW'(r2_handle) - BPW'(r2_bin) * BPW'(PAGES_PER_BIN);
    assign o_item    = {r2_op, need_full[sba_pkg::SIZE_W-1:0], r2_bin, slot_full[SW-1:0]};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (load1) begin
                r1_vld <= 1'b1;
            end else if (load2) begin
                r1_vld <= 1'b0;
            end
            if (load2) begin
                r2_vld <= 1'b1;
            end else if (adv2) begin
                r2_vld <= 1'b0;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r1_op     <= i_opcode;
            r1_x      <= sba_pkg::SIZE_W'(i_request_size) + sba_pkg::SIZE_W'(ALIGN_BYTES - 1);
            r1_handle <= i_slot_handle;
        end
        if (load2) begin
            r2_op     <= r1_op;
            r2_q      <= shr1[sba_pkg::SIZE_W-1:0];
            r2_bin    <= shr2[sba_pkg::HANDLE_W-1:0];
            r2_handle <= r1_handle;
        end
    end

endmodule

// File: rtl/sba_queue.sv
`timescale 1ns / 1ps

module sba_queue #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_buf[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/sba_back.sv
`timescale 1ns / 1ps

module sba_back #(
    parameter int MAX_BINS      = 16,
    parameter int PAGES_PER_BIN = 8,
    parameter int SW            = 3,
    parameter int ITEM_W        = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ITEM_W-1:0]            i_item,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [sba_pkg::HANDLE_W-1:0] o_granted_handle,
    output logic [sba_pkg::SIZE_W-1:0]   o_granted_slot_size
);

    localparam int BW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW   = $clog2(MAX_BINS + 1);
    localparam int CMPW = sba_pkg::HANDLE_W + 1;
    localparam int HPW  = BW + sba_pkg::HANDLE_W;
    localparam logic [PAGES_PER_BIN-1:0] INIT_FREE = ~(PAGES_PER_BIN'(1));

    sba_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]                r_bins, n_bins;
    logic [CW-1:0]                r_iss, n_iss;
    logic                         r_dv, n_dv;
    logic [BW-1:0]                r_chk, n_chk;
    logic                         r_op, n_op;
    logic [sba_pkg::SIZE_W-1:0]   r_need, n_need;
    logic [sba_pkg::HANDLE_W-1:0] r_bin, n_bin;
    logic [SW-1:0]                r_slot, n_slot;

    sba_pkg::t_status             r_res_status, n_res_status;
    logic [BW-1:0]                r_res_bin, n_res_bin;
    logic [SW-1:0]                r_res_slot, n_res_slot;
    logic [sba_pkg::SIZE_W-1:0]   r_res_size, n_res_size;

    logic                         r_out_vld, n_out_vld;
    sba_pkg::t_status             r_out_status;

    // head of queue
    logic                         h_op;
    logic [sba_pkg::SIZE_W-1:0]   h_need;
    logic [sba_pkg::HANDLE_W-1:0] h_bin;
    logic [SW-1:0]                h_slot;
    logic                         h_bin_ok;

    // memory ports
    logic                         re, size_we, free_we;
    logic [BW-1:0]                raddr, waddr;
    logic [sba_pkg::SIZE_W-1:0]   size_wdata, size_q;
    logic [PAGES_PER_BIN-1:0]     free_wdata, free_q, free_iso, slot_bit;
    logic [SW-1:0]                low_slot;

    logic                         hit, more, out_free, load_out;
    logic [HPW-1:0]               handle_full;

    assign {h_op, h_need, h_bin, h_slot} = i_item;
    assign h_bin_ok = CMPW'(h_bin) < CMPW'(r_bins);

    sba_ram #(
        .WIDTH (sba_pkg::SIZE_W),
        .DEPTH (MAX_BINS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (waddr),
        .i_wdata (size_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (size_q)
    );

    sba_ram #(
        .WIDTH (PAGES_PER_BIN),
        .DEPTH (MAX_BINS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (waddr),
        .i_wdata (free_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (free_q)
    );

    // lowest free slot of the bin just read
    assign free_iso = free_q & (~free_q + 1'b1);
    always_comb begin
        low_slot = '0;
        for (int i = 0; i < PAGES_PER_BIN; i++) begin
            if (free_iso[i]) begin
                low_slot = low_slot | SW'(i);
            end
        end
    end

    assign slot_bit = PAGES_PER_BIN'(1) << r_slot;
    assign hit      = r_dv && (size_q >= r_need) && (free_q != '0);
    assign more     = r_iss < r_bins;
    assign out_free = !r_out_vld || !i_stall;
    assign load_out = (r_state == sba_pkg::BK_DONE) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sba_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    if (h_op == sba_pkg::OP_ALLOC) begin
                        n_state = sba_pkg::BK_SCAN;
                    end else if (h_bin_ok) begin
                        n_state = sba_pkg::BK_FREE_CHK;
                    end else begin
                        n_state = sba_pkg::BK_DONE;
                    end
                end
            end
            sba_pkg::BK_SCAN: begin
                if (hit || !more) begin
                    n_state = sba_pkg::BK_DONE;
                end
            end
            sba_pkg::BK_FREE_CHK: begin
                n_state = sba_pkg::BK_DONE;
            end
            sba_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = sba_pkg::BK_IDLE;
                end
            end
            default: n_state = sba_pkg::BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_bins       = r_bins;
        n_iss        = r_iss;
        n_dv         = r_dv;
        n_chk        = r_chk;
        n_op         = r_op;
        n_need       = r_need;
        n_bin        = r_bin;
        n_slot       = r_slot;
        n_res_status = r_res_status;
        n_res_bin    = r_res_bin;
        n_res_slot   = r_res_slot;
        n_res_size   = r_res_size;
        o_pop        = 1'b0;
        re           = 1'b0;
        raddr        = '0;
        size_we      = 1'b0;
        free_we      = 1'b0;
        waddr        = '0;
        size_wdata   = r_need;
        free_wdata   = free_q;
        unique case (r_state)
            sba_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_op   = h_op;
                    n_need = h_need;
                    n_bin  = h_bin;
                    n_slot = h_slot;
                    n_iss  = '0;
                    n_dv   = 1'b0;
                    if (h_op == sba_pkg::OP_FREE) begin
                        if (h_bin_ok) begin
                            re    = 1'b1;
                            raddr = h_bin[BW-1:0];
                        end else begin
                            n_res_status = sba_pkg::ST_NOT_ALLOCATED;
                            n_res_bin    = '0;
                            n_res_slot   = '0;
                            n_res_size   = '0;
                        end
                    end
                end
            end
            sba_pkg::BK_SCAN: begin
                if (hit) begin
                    // first fitting bin: take its lowest free slot
                    free_we      = 1'b1;
                    waddr        = r_chk;
                    free_wdata   = free_q & ~free_iso;
                    n_res_status = sba_pkg::ST_ALLOCATED;
                    n_res_bin    = r_chk;
                    n_res_slot   = low_slot;
                    n_res_size   = size_q;
                end else if (more) begin
                    // read the next bin in creation order
                    re    = 1'b1;
                    raddr = r_iss[BW-1:0];
                    n_chk = r_iss[BW-1:0];
                    n_iss = r_iss + 1'b1;
                    n_dv  = 1'b1;
                end else if (r_bins == CW'(MAX_BINS)) begin
                    n_res_status = sba_pkg::ST_NO_SPACE;
                    n_res_bin    = '0;
                    n_res_slot   = '0;
                    n_res_size   = '0;
                end else begin
                    // no bin fits: create one and take slot 0
                    size_we      = 1'b1;
                    free_we      = 1'b1;
                    waddr        = r_bins[BW-1:0];
                    size_wdata   = r_need;
                    free_wdata   = INIT_FREE;
                    n_bins       = r_bins + 1'b1;
                    n_res_status = sba_pkg::ST_ALLOCATED;
                    n_res_bin    = r_bins[BW-1:0];
                    n_res_slot   = '0;
                    n_res_size   = r_need;
                end
            end
            sba_pkg::BK_FREE_CHK: begin
                n_res_bin  = '0;
                n_res_slot = '0;
                n_res_size = '0;
                if ((free_q & slot_bit) != '0) begin
                    n_res_status = sba_pkg::ST_NOT_ALLOCATED;
                end else begin
                    free_we      = 1'b1;
                    waddr        = r_bin[BW-1:0];
                    free_wdata   = free_q | slot_bit;
                    n_res_status = sba_pkg::ST_FREED;
                end
            end
            sba_pkg::BK_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign handle_full = HPW'(r_res_bin) * HPW'(PAGES_PER_BIN) + HPW'(r_res_slot);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sba_pkg::BK_IDLE;
            r_bins    <= '0;
            r_iss     <= '0;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bins    <= n_bins;
            r_iss     <= n_iss;
            r_dv      <= n_dv;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk        <= n_chk;
        r_op         <= n_op;
        r_need       <= n_need;
        r_bin        <= n_bin;
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_bin    <= n_res_bin;
        r_res_slot   <= n_res_slot;
        r_res_size   <= n_res_size;
        if (load_out) begin
            r_out_status        <= r_res_status;
            o_granted_handle    <= handle_full[sba_pkg::HANDLE_W-1:0];
            o_granted_slot_size <= r_res_size;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;

endmodule

// File: rtl/slab_bin_allocator.sv
`timescale 1ns / 1ps

// First-fit slab allocator over a table of up to MAX_BINS bins.
// Input channel (i_valid / o_stall): one request per transfer, i_opcode
// selects allocate (i_request_size) or free (i_slot_handle).
// Output channel (o_valid / i_stall): exactly one result per request, in
// order: o_status, o_granted_handle, o_granted_slot_size.
// A front pipeline (two stages) rounds the size up to ALIGN_BYTES and splits
// the handle into bin and slot; a two-entry queue feeds the back end, which
// holds the bin table in two small RAMs and scans it one bin per cycle.
// The back end takes one item at a time: IDLE, then SCAN or FREE_CHK where
// needed, then DONE. A free with a valid bin does one RAM read; an allocate
// reads the bins in use in creation order, one RAM read per cycle, until one
// fits, while the front and the queue go on accepting items.
// Reset empties the bin table (bins_in_use = 0), the queue and all stages.
// When the receiver stalls, the result holds in the output register; the
// back end finishes the next item and waits, the queue and front fill up,
// and o_stall then rises.

module slab_bin_allocator #(
    parameter int MAX_BINS      = 16,
    parameter int PAGES_PER_BIN = 8,
    parameter int ALIGN_BYTES   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [sba_pkg::REQ_W-1:0]    i_request_size,
    input  logic [sba_pkg::HANDLE_W-1:0] i_slot_handle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [sba_pkg::HANDLE_W-1:0] o_granted_handle,
    output logic [sba_pkg::SIZE_W-1:0]   o_granted_slot_size
);

    localparam int SW     = (PAGES_PER_BIN > 1) ? $clog2(PAGES_PER_BIN) : 1;
    localparam int ITEM_W = 1 + sba_pkg::SIZE_W + sba_pkg::HANDLE_W + SW;

    logic              push, full, pop, empty;
    logic [ITEM_W-1:0] push_item, head_item;

    // request classification
    sba_front #(
        .PAGES_PER_BIN (PAGES_PER_BIN),
        .ALIGN_BYTES   (ALIGN_BYTES),
        .SW            (SW),
        .ITEM_W        (ITEM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_slot_handle  (i_slot_handle),
        .o_push         (push),
        .o_item         (push_item),
        .i_full         (full)
    );

    // decoupling queue
    sba_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_empty (empty)
    );

    // bin table and result register
    sba_back #(
        .MAX_BINS      (MAX_BINS),
        .PAGES_PER_BIN (PAGES_PER_BIN),
        .SW            (SW),
        .ITEM_W        (ITEM_W)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item              (head_item),
        .i_empty             (empty),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_granted_handle    (o_granted_handle),
        .o_granted_slot_size (o_granted_slot_size)
    );

endmodule
